[sv/ppf_pkg.sv]
`timescale 1ns / 1ps
package ppf_pkg;

	// item field widths
	localparam int COORD_W = 24;
	localparam int NORM_W = 16;
	localparam int DSQ_W = 50;
	localparam int DIST_W = 25;
	localparam int ANG_W = 15;
	localparam int ANGLE_FRAC_BITS = 14;

	// internal widths
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W = 2 * DIFF_W - 2;
	localparam int SUM_W = SQ_W + 2;
	localparam int PROD_W = NORM_W + DIFF_W;
	localparam int DOT_W = PROD_W + 2;
	localparam int NU_W = DOT_W + 1;
	localparam int PRODN_W = 2 * NORM_W;
	localparam int DOTN_W = PRODN_W + 2;
	localparam int COS_W = 17;

	// square root cells: two radicand bits per cell
	localparam int RAD_W = 64;
	localparam int ROOT_W = 32;
	localparam int REM_W = ROOT_W + 3;
	localparam int SQ_STEPS = DSQ_W / 2;
	localparam int SIN_STEPS = 31;

	// divider cells: one quotient bit per cell
	localparam int DIV_STEPS = 16;
	localparam int DVS_W = 26;
	localparam int DREM_W = DVS_W + 1;

	// vectoring rotation cells
	localparam int CORDIC_STEPS = 24;
	localparam int XY_W = 34;
	localparam int Z_W = 33;
	localparam int STEP_W = 5;

	// acos unit latency: input register, sine root, rotations, output register
	localparam int ACOS_LAT = 1 + SIN_STEPS + CORDIC_STEPS + 1;

	localparam logic [DSQ_W-1:0] DSQ_MAX = {DSQ_W{1'b1}};
	localparam logic [DSQ_W-1:0] MAX_DSQ_RST = 50'h3000000000000;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [ANG_W-1:0] ANGLE_MAX = 15'h7fff;
	localparam logic [COS_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 33'sd1686629713;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SAME = 2'd1,
		ST_BAND = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_MIN_DIST_SQ = 1'b0,
		REG_MAX_DIST_SQ = 1'b1
	} cfg_reg_t;

	// atan(2^-i), Q.30, truncated
	function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] i);
		logic [29:0] a;
		begin
			case (i)
				5'd0: a = 30'h3243F6A8;
				5'd1: a = 30'h1DAC6705;
				5'd2: a = 30'h0FADBAFC;
				5'd3: a = 30'h07F56EA6;
				5'd4: a = 30'h03FEAB76;
				5'd5: a = 30'h01FFD55B;
				5'd6: a = 30'h00FFFAAA;
				5'd7: a = 30'h007FFF55;
				5'd8: a = 30'h003FFFEA;
				5'd9: a = 30'h001FFFFD;
				5'd10: a = 30'h000FFFFF;
				5'd11: a = 30'h0007FFFF;
				5'd12: a = 30'h0003FFFF;
				5'd13: a = 30'h0001FFFF;
				5'd14: a = 30'h0000FFFF;
				5'd15: a = 30'h00007FFF;
				5'd16: a = 30'h00003FFF;
				5'd17: a = 30'h00001FFF;
				5'd18: a = 30'h00000FFF;
				5'd19: a = 30'h000007FF;
				5'd20: a = 30'h000003FF;
				5'd21: a = 30'h000001FF;
				5'd22: a = 30'h000000FF;
				5'd23: a = 30'h0000007F;
				default: a = 30'h0;
			endcase
			return a;
		end
	endfunction

endpackage

[sv/point_pair_feature.sv]
`timescale 1ns / 1ps
// Oriented point pair feature. One item (two points with normals) is taken in
// every cycle: busy never rises. Each item gives exactly one result, shown for
// one cycle with done high, in the order taken. The pipeline is built mainly
// from rows of cells: a 25-cell square root for the distance, a 16-cell divider
// for each of the two direction cosines, and per angle a 31-cell root plus 24
// rotation cells.
// The receiver cannot stall, so results must be taken as they appear.
// Band registers are written through cfg_valid/cfg_ready (always ready) and
// should only change while no item is in flight.
module point_pair_feature (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [ppf_pkg::COORD_W-1:0]   first_pos_x,
	input  logic signed [ppf_pkg::COORD_W-1:0]   first_pos_y,
	input  logic signed [ppf_pkg::COORD_W-1:0]   first_pos_z,
	input  logic signed [ppf_pkg::NORM_W-1:0]    first_norm_x,
	input  logic signed [ppf_pkg::NORM_W-1:0]    first_norm_y,
	input  logic signed [ppf_pkg::NORM_W-1:0]    first_norm_z,
	input  logic signed [ppf_pkg::COORD_W-1:0]   second_pos_x,
	input  logic signed [ppf_pkg::COORD_W-1:0]   second_pos_y,
	input  logic signed [ppf_pkg::COORD_W-1:0]   second_pos_z,
	input  logic signed [ppf_pkg::NORM_W-1:0]    second_norm_x,
	input  logic signed [ppf_pkg::NORM_W-1:0]    second_norm_y,
	input  logic signed [ppf_pkg::NORM_W-1:0]    second_norm_z,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [ppf_pkg::DSQ_W-1:0]            cfg_data,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [ppf_pkg::DSQ_W-1:0]            distance_sq,
	output logic [ppf_pkg::DIST_W-1:0]           distance,
	output logic [ppf_pkg::ANG_W-1:0]            normal_angle,
	output logic [ppf_pkg::ANG_W-1:0]            small_angle,
	output logic [ppf_pkg::ANG_W-1:0]            large_angle
);
	import ppf_pkg::*;

	// side data travelling next to each row of cells
	typedef struct packed {
		status_t             status;
		logic [DSQ_W-1:0]    dsq;
		logic [COS_W-1:0]    cos_n;
		logic [NU_W-1:0]     nu;
		logic [NU_W-1:0]     nv;
	} sq_side_t;

	typedef struct packed {
		status_t             status;
		logic [DSQ_W-1:0]    dsq;
		logic [DIST_W-1:0]   dlen;
		logic [COS_W-1:0]    cos_n;
		logic                ovu;
		logic                ovv;
	} dv_side_t;

	typedef struct packed {
		status_t             status;
		logic [DSQ_W-1:0]    dsq;
		logic [DIST_W-1:0]   dlen;
	} ac_side_t;

	// band registers
	logic [DSQ_W-1:0] min_dsq_q;
	logic [DSQ_W-1:0] max_dsq_q;

	logic accept;

	logic signed [COORD_W-1:0] p1 [3];
	logic signed [COORD_W-1:0] p2 [3];
	logic signed [NORM_W-1:0] n1 [3];
	logic signed [NORM_W-1:0] n2 [3];

	// stage 1: differences
	logic v_s1;
	logic signed [DIFF_W-1:0] d_s1 [3];
	logic signed [NORM_W-1:0] n1_s1 [3];
	logic signed [NORM_W-1:0] n2_s1 [3];

	// stage 2: products
	logic v_s2;
	logic signed [2*DIFF_W-1:0] sq_full [3];
	logic [SQ_W-1:0] sq_s2 [3];
	logic signed [PROD_W-1:0] pu_s2 [3];
	logic signed [PROD_W-1:0] pv_s2 [3];
	logic signed [PRODN_W-1:0] pn_s2 [3];

	// stage 3: sums
	logic v_s3;
	logic [SUM_W-1:0] dsum;
	logic [DSQ_W-1:0] dsq_s3;
	logic signed [DOT_W-1:0] dot_u_s3;
	logic signed [DOT_W-1:0] dot_v_s3;
	logic signed [DOTN_W-1:0] dot_n_s3;

	// stage 4: status, magnitudes
	logic v_s4;
	sq_side_t side_s4;
	logic [DOT_W-1:0] abs_u;
	logic [DOT_W-1:0] abs_v;
	logic [DOTN_W-1:0] abs_n;
	logic [DOTN_W-15:0] cn_raw;

	// distance root row
	logic [RAD_W-1:0] rad_w [SQ_STEPS+1];
	logic [REM_W-1:0] rem_w [SQ_STEPS+1];
	logic [ROOT_W-1:0] root_w [SQ_STEPS+1];
	sq_side_t sq_side_q [SQ_STEPS];
	logic [SQ_STEPS-1:0] sq_v_q;

	// stage 5: rounding, divider set-up
	sq_side_t sq_end;
	logic rnd_up;
	logic [DVS_W-1:0] rp;
	logic [NU_W-1:0] rp_sh;
	logic v_s5;
	dv_side_t side_s5;
	logic [DVS_W-1:0] dvs_s5;
	logic [DREM_W-1:0] remu_s5;
	logic [DREM_W-1:0] remv_s5;
	logic [DIV_STEPS-1:0] numu_s5;
	logic [DIV_STEPS-1:0] numv_s5;

	// divider rows, one per direction cosine
	logic [DREM_W-1:0] dru_w [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dnu_w [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dqu_w [DIV_STEPS+1];
	logic [DVS_W-1:0] ddu_w [DIV_STEPS+1];
	logic [DREM_W-1:0] drv_w [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dnv_w [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dqv_w [DIV_STEPS+1];
	logic [DVS_W-1:0] ddv_w [DIV_STEPS+1];
	dv_side_t dv_side_q [DIV_STEPS];
	logic [DIV_STEPS-1:0] dv_v_q;

	// stage 6: cosines
	dv_side_t dv_end;
	logic v_s6;
	ac_side_t side_s6;
	logic [COS_W-1:0] cu_s6;
	logic [COS_W-1:0] cv_s6;
	logic [COS_W-1:0] cn_s6;

	// acos units
	logic [ANG_W-1:0] ang_u;
	logic [ANG_W-1:0] ang_v;
	logic [ANG_W-1:0] ang_n;
	ac_side_t ac_side_q [ACOS_LAT];
	logic [ACOS_LAT-1:0] ac_v_q;
	ac_side_t ac_end;
	logic u_lt_v;

	// result registers
	logic done_q;
	status_t status_q;
	logic [DSQ_W-1:0] dsq_q;
	logic [DIST_W-1:0] dist_q;
	logic [ANG_W-1:0] ang_n_q;
	logic [ANG_W-1:0] ang_s_q;
	logic [ANG_W-1:0] ang_l_q;

	// fully pipelined: every cycle takes an item
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dsq_q <= '0;
			max_dsq_q <= MAX_DSQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_DIST_SQ: min_dsq_q <= cfg_data;
				REG_MAX_DIST_SQ: max_dsq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign p1[0] = first_pos_x;
	assign p1[1] = first_pos_y;
	assign p1[2] = first_pos_z;
	assign p2[0] = second_pos_x;
	assign p2[1] = second_pos_y;
	assign p2[2] = second_pos_z;
	assign n1[0] = first_norm_x;
	assign n1[1] = first_norm_y;
	assign n1[2] = first_norm_z;
	assign n2[0] = second_norm_x;
	assign n2[1] = second_norm_y;
	assign n2[2] = second_norm_z;

	// valid flags of all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			sq_v_q <= '0;
			dv_v_q <= '0;
			ac_v_q <= '0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			sq_v_q <= {sq_v_q[SQ_STEPS-2:0], v_s4};
			v_s5 <= sq_v_q[SQ_STEPS-1];
			dv_v_q <= {dv_v_q[DIV_STEPS-2:0], v_s5};
			v_s6 <= dv_v_q[DIV_STEPS-1];
			ac_v_q <= {ac_v_q[ACOS_LAT-2:0], v_s6};
			done_q <= ac_v_q[ACOS_LAT-1];
		end
	end

	// stage 1: d = second - first
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			d_s1[k] <= {p2[k][COORD_W-1], p2[k]} - {p1[k][COORD_W-1], p1[k]};
			n1_s1[k] <= n1[k];
			n2_s1[k] <= n2[k];
		end
	end

	// stage 2: squares and dot product terms
	always_comb begin
		for (int k = 0; k < 3; k++)
			sq_full[k] = d_s1[k] * d_s1[k];
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= sq_full[k][SQ_W-1:0];
			pu_s2[k] <= n1_s1[k] * d_s1[k];
			pv_s2[k] <= n2_s1[k] * d_s1[k];
			pn_s2[k] <= n1_s1[k] * n2_s1[k];
		end
	end

	// stage 3: sums
	assign dsum = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);

	always_ff @(posedge clk) begin
		dsq_s3 <= (dsum > SUM_W'(DSQ_MAX)) ? DSQ_MAX : DSQ_W'(dsum);
		dot_u_s3 <= DOT_W'(pu_s2[0]) + DOT_W'(pu_s2[1]) + DOT_W'(pu_s2[2]);
		dot_v_s3 <= DOT_W'(pv_s2[0]) + DOT_W'(pv_s2[1]) + DOT_W'(pv_s2[2]);
		dot_n_s3 <= DOTN_W'(pn_s2[0]) + DOTN_W'(pn_s2[1]) + DOTN_W'(pn_s2[2]);
	end

	// stage 4: classify, take magnitudes; normal cosine is |n1.n2| >> 14
	always_comb begin
		abs_u = dot_u_s3[DOT_W-1] ? DOT_W'(-dot_u_s3) : DOT_W'(dot_u_s3);
		abs_v = dot_v_s3[DOT_W-1] ? DOT_W'(-dot_v_s3) : DOT_W'(dot_v_s3);
		abs_n = dot_n_s3[DOTN_W-1] ? DOTN_W'(-dot_n_s3) : DOTN_W'(dot_n_s3);
		cn_raw = abs_n[DOTN_W-1:14];
	end

	always_ff @(posedge clk) begin
		if (dsq_s3 == '0)
			side_s4.status <= ST_SAME;
		else if (dsq_s3 < min_dsq_q || dsq_s3 > max_dsq_q)
			side_s4.status <= ST_BAND;
		else
			side_s4.status <= ST_OK;
		side_s4.dsq <= dsq_s3;
		side_s4.cos_n <= (cn_raw > (DOTN_W-14)'(ONE_Q16)) ? ONE_Q16 : cn_raw[COS_W-1:0];
		side_s4.nu <= {abs_u, 1'b0};
		side_s4.nv <= {abs_v, 1'b0};
	end

	// distance root: radicand in the top bits of the row
	assign rad_w[0] = {side_s4.dsq, {(RAD_W-DSQ_W){1'b0}}};
	assign rem_w[0] = '0;
	assign root_w[0] = '0;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_root
		ppf_sqrt_cell u_cell (
			.clk    (clk),
			.rad_i  (rad_w[k]),
			.rem_i  (rem_w[k]),
			.root_i (root_w[k]),
			.rad_o  (rad_w[k+1]),
			.rem_o  (rem_w[k+1]),
			.root_o (root_w[k+1])
		);
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				sq_side_q[k] <= side_s4;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				sq_side_q[k] <= sq_side_q[k-1];
			end
		end
	end

	// stage 5: round to nearest (remainder above root means round up),
	// then set up the dividers; a quotient of 1.0 or more is caught here
	always_comb begin
		sq_end = sq_side_q[SQ_STEPS-1];
		rnd_up = (rem_w[SQ_STEPS] > {{(REM_W-ROOT_W){1'b0}}, root_w[SQ_STEPS]});
		rp = root_w[SQ_STEPS][DVS_W-1:0] + DVS_W'(rnd_up);
		rp_sh = NU_W'({rp, {DIV_STEPS{1'b0}}});
	end

	always_ff @(posedge clk) begin
		side_s5.status <= sq_end.status;
		side_s5.dsq <= sq_end.dsq;
		side_s5.dlen <= (rp > DVS_W'(DIST_MAX)) ? DIST_MAX : rp[DIST_W-1:0];
		side_s5.cos_n <= sq_end.cos_n;
		side_s5.ovu <= (sq_end.nu >= rp_sh);
		side_s5.ovv <= (sq_end.nv >= rp_sh);
		dvs_s5 <= rp;
		remu_s5 <= (sq_end.nu >= rp_sh) ? '0 : sq_end.nu[DREM_W+DIV_STEPS-1:DIV_STEPS];
		remv_s5 <= (sq_end.nv >= rp_sh) ? '0 : sq_end.nv[DREM_W+DIV_STEPS-1:DIV_STEPS];
		numu_s5 <= sq_end.nu[DIV_STEPS-1:0];
		numv_s5 <= sq_end.nv[DIV_STEPS-1:0];
	end

	assign dru_w[0] = remu_s5;
	assign dnu_w[0] = numu_s5;
	assign dqu_w[0] = '0;
	assign ddu_w[0] = dvs_s5;
	assign drv_w[0] = remv_s5;
	assign dnv_w[0] = numv_s5;
	assign dqv_w[0] = '0;
	assign ddv_w[0] = dvs_s5;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		ppf_div_cell u_cell_u (
			.clk   (clk),
			.rem_i (dru_w[k]),
			.num_i (dnu_w[k]),
			.quo_i (dqu_w[k]),
			.dvs_i (ddu_w[k]),
			.rem_o (dru_w[k+1]),
			.num_o (dnu_w[k+1]),
			.quo_o (dqu_w[k+1]),
			.dvs_o (ddu_w[k+1])
		);
		ppf_div_cell u_cell_v (
			.clk   (clk),
			.rem_i (drv_w[k]),
			.num_i (dnv_w[k]),
			.quo_i (dqv_w[k]),
			.dvs_i (ddv_w[k]),
			.rem_o (drv_w[k+1]),
			.num_o (dnv_w[k+1]),
			.quo_o (dqv_w[k+1]),
			.dvs_o (ddv_w[k+1])
		);
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				dv_side_q[k] <= side_s5;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				dv_side_q[k] <= dv_side_q[k-1];
			end
		end
	end

	// stage 6: clamped cosines
	assign dv_end = dv_side_q[DIV_STEPS-1];

	always_ff @(posedge clk) begin
		side_s6.status <= dv_end.status;
		side_s6.dsq <= dv_end.dsq;
		side_s6.dlen <= dv_end.dlen;
		cu_s6 <= dv_end.ovu ? ONE_Q16 : {1'b0, dqu_w[DIV_STEPS]};
		cv_s6 <= dv_end.ovv ? ONE_Q16 : {1'b0, dqv_w[DIV_STEPS]};
		cn_s6 <= dv_end.cos_n;
	end

	ppf_acos u_acos_n (.clk(clk), .cos_i(cn_s6), .angle(ang_n));
	ppf_acos u_acos_u (.clk(clk), .cos_i(cu_s6), .angle(ang_u));
	ppf_acos u_acos_v (.clk(clk), .cos_i(cv_s6), .angle(ang_v));

	for (genvar k = 0; k < ACOS_LAT; k++) begin : g_acd
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				ac_side_q[k] <= side_s6;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				ac_side_q[k] <= ac_side_q[k-1];
			end
		end
	end

	// result stage: sort the two direction angles, zero what the status hides
	assign ac_end = ac_side_q[ACOS_LAT-1];
	assign u_lt_v = (ang_u < ang_v);

	always_ff @(posedge clk) begin
		status_q <= ac_end.status;
		dsq_q <= ac_end.dsq;
		if (ac_end.status == ST_OK) begin
			dist_q <= ac_end.dlen;
			ang_n_q <= ang_n;
			ang_s_q <= u_lt_v ? ang_u : ang_v;
			ang_l_q <= u_lt_v ? ang_v : ang_u;
		end else begin
			dist_q <= '0;
			ang_n_q <= '0;
			ang_s_q <= '0;
			ang_l_q <= '0;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign distance_sq = dsq_q;
	assign distance = dist_q;
	assign normal_angle = ang_n_q;
	assign small_angle = ang_s_q;
	assign large_angle = ang_l_q;

endmodule

[sv/ppf_sqrt_cell.sv]
`timescale 1ns / 1ps
// one digit of a restoring square root: two radicand bits in, one root bit out
module ppf_sqrt_cell (
	input  logic                         clk,
	input  logic [ppf_pkg::RAD_W-1:0]    rad_i,
	input  logic [ppf_pkg::REM_W-1:0]    rem_i,
	input  logic [ppf_pkg::ROOT_W-1:0]   root_i,
	output logic [ppf_pkg::RAD_W-1:0]    rad_o,
	output logic [ppf_pkg::REM_W-1:0]    rem_o,
	output logic [ppf_pkg::ROOT_W-1:0]   root_o
);
	import ppf_pkg::*;

	logic [REM_W-1:0] cur;
	logic [REM_W-1:0] trial;
	logic ge;

	always_comb begin
		cur = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		ge = (cur >= trial);
	end

	always_ff @(posedge clk) begin
		rad_o <= {rad_i[RAD_W-3:0], 2'b00};
		rem_o <= ge ? (cur - trial) : cur;
		root_o <= {root_i[ROOT_W-2:0], ge};
	end

endmodule

[sv/ppf_div_cell.sv]
`timescale 1ns / 1ps
// one quotient bit of a restoring division
module ppf_div_cell (
	input  logic                            clk,
	input  logic [ppf_pkg::DREM_W-1:0]      rem_i,
	input  logic [ppf_pkg::DIV_STEPS-1:0]   num_i,
	input  logic [ppf_pkg::DIV_STEPS-1:0]   quo_i,
	input  logic [ppf_pkg::DVS_W-1:0]       dvs_i,
	output logic [ppf_pkg::DREM_W-1:0]      rem_o,
	output logic [ppf_pkg::DIV_STEPS-1:0]   num_o,
	output logic [ppf_pkg::DIV_STEPS-1:0]   quo_o,
	output logic [ppf_pkg::DVS_W-1:0]       dvs_o
);
	import ppf_pkg::*;

	logic [DREM_W-1:0] cur;
	logic [DREM_W-1:0] dvs_ext;
	logic ge;

	always_comb begin
		cur = {rem_i[DREM_W-2:0], num_i[DIV_STEPS-1]};
		dvs_ext = {1'b0, dvs_i};
		ge = (cur >= dvs_ext);
	end

	always_ff @(posedge clk) begin
		rem_o <= ge ? (cur - dvs_ext) : cur;
		num_o <= {num_i[DIV_STEPS-2:0], 1'b0};
		quo_o <= {quo_i[DIV_STEPS-2:0], ge};
		dvs_o <= dvs_i;
	end

endmodule

[sv/ppf_cordic_cell.sv]
`timescale 1ns / 1ps
// one vectoring rotation; step_i is tied to the cell's place in the row
module ppf_cordic_cell (
	input  logic                               clk,
	input  logic [ppf_pkg::STEP_W-1:0]         step_i,
	input  logic signed [ppf_pkg::XY_W-1:0]    x_i,
	input  logic signed [ppf_pkg::XY_W-1:0]    y_i,
	input  logic signed [ppf_pkg::Z_W-1:0]     z_i,
	output logic signed [ppf_pkg::XY_W-1:0]    x_o,
	output logic signed [ppf_pkg::XY_W-1:0]    y_o,
	output logic signed [ppf_pkg::Z_W-1:0]     z_o
);
	import ppf_pkg::*;

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0] ang;

	always_comb begin
		xs = x_i >>> step_i;
		ys = y_i >>> step_i;
		ang = $signed({3'b000, atan_q30(step_i)});
	end

	always_ff @(posedge clk) begin
		if (y_i > 0) begin
			x_o <= x_i + ys;
			y_o <= y_i - xs;
			z_o <= z_i + ang;
		end else begin
			x_o <= x_i - ys;
			y_o <= y_i + xs;
			z_o <= z_i - ang;
		end
	end

endmodule

[sv/ppf_acos.sv]
`timescale 1ns / 1ps
// acos of a Q.16 cosine in [0, 1]: sine by a row of root cells, then
// atan2(sine, cosine) by a row of rotation cells.
module ppf_acos (
	input  logic                          clk,
	input  logic [ppf_pkg::COS_W-1:0]     cos_i,
	output logic [ppf_pkg::ANG_W-1:0]     angle
);
	import ppf_pkg::*;

	localparam int X0_W = COS_W + 14;

	logic [COS_W-1:0] c_s1;
	logic [2*COS_W-1:0] csq_s1;
	logic one_s1;
	logic [32:0] sdiff;

	logic [RAD_W-1:0] rad_w [SIN_STEPS+1];
	logic [REM_W-1:0] rem_w [SIN_STEPS+1];
	logic [ROOT_W-1:0] root_w [SIN_STEPS+1];
	logic [X0_W-1:0] x0_q [SIN_STEPS];
	logic [SIN_STEPS-1:0] one_sq_q;

	logic signed [XY_W-1:0] x_w [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] y_w [CORDIC_STEPS+1];
	logic signed [Z_W-1:0] z_w [CORDIC_STEPS+1];
	logic [CORDIC_STEPS-1:0] one_cr_q;

	logic [30:0] zc;
	logic [31:0] rsum;
	logic [31:0] rq;
	logic [ANG_W-1:0] angle_q;

	always_ff @(posedge clk) begin
		c_s1 <= cos_i;
		csq_s1 <= cos_i * cos_i;
		one_s1 <= (cos_i >= ONE_Q16);
	end

	// 1 - c^2 in Q.32, placed so the root comes out in Q.30
	assign sdiff = 33'h100000000 - csq_s1[32:0];
	assign rad_w[0] = {1'b0, sdiff, 30'b0};
	assign rem_w[0] = '0;
	assign root_w[0] = '0;

	for (genvar k = 0; k < SIN_STEPS; k++) begin : g_sin
		ppf_sqrt_cell u_cell (
			.clk    (clk),
			.rad_i  (rad_w[k]),
			.rem_i  (rem_w[k]),
			.root_i (root_w[k]),
			.rad_o  (rad_w[k+1]),
			.rem_o  (rem_w[k+1]),
			.root_o (root_w[k+1])
		);
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				x0_q[k] <= {c_s1, 14'b0};
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				x0_q[k] <= x0_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		one_sq_q <= {one_sq_q[SIN_STEPS-2:0], one_s1};
		one_cr_q <= {one_cr_q[CORDIC_STEPS-2:0], one_sq_q[SIN_STEPS-1]};
	end

	assign x_w[0] = $signed({{(XY_W-X0_W){1'b0}}, x0_q[SIN_STEPS-1]});
	assign y_w[0] = $signed({3'b000, root_w[SIN_STEPS][30:0]});
	assign z_w[0] = '0;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		ppf_cordic_cell u_cell (
			.clk    (clk),
			.step_i (STEP_W'(k)),
			.x_i    (x_w[k]),
			.y_i    (y_w[k]),
			.z_i    (z_w[k]),
			.x_o    (x_w[k+1]),
			.y_o    (y_w[k+1]),
			.z_o    (z_w[k+1])
		);
	end

	// clamp to [0, pi/2], round half up
	always_comb begin
		if (z_w[CORDIC_STEPS] < 0)
			zc = '0;
		else if (z_w[CORDIC_STEPS] > HALF_PI_Q30)
			zc = HALF_PI_Q30[30:0];
		else
			zc = z_w[CORDIC_STEPS][30:0];
		rsum = {1'b0, zc} + (32'd1 << (29 - ANGLE_FRAC_BITS));
		rq = rsum >> (30 - ANGLE_FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (one_cr_q[CORDIC_STEPS-1])
			angle_q <= '0;
		else if (rq > 32'(ANGLE_MAX))
			angle_q <= ANGLE_MAX;
		else
			angle_q <= rq[ANG_W-1:0];
	end

	assign angle = angle_q;

endmodule

[dv/tb_point_pair_feature.sv]
`timescale 1ns / 1ps
module tb_point_pair_feature;
	import ppf_pkg::*;

	localparam int LIMIT = 600000;   // cycles before the run is abandoned
	localparam int SETTLE = 120;     // wait that exceeds the pipeline depth
	localparam longint unsigned DSQ_TOP = (64'd1 << DSQ_W) - 1;

	// atan(2^-i) in Q.30, truncated
	localparam longint ATAN_TAB [CORDIC_STEPS] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

	typedef struct {
		logic signed [COORD_W-1:0] fp [3];
		logic signed [NORM_W-1:0]  fn [3];
		logic signed [COORD_W-1:0] sp [3];
		logic signed [NORM_W-1:0]  sn [3];
	} pair_t;

	typedef struct {
		status_t           st;
		logic [DSQ_W-1:0]  dsq;
		logic [DIST_W-1:0] dlen;
		logic [ANG_W-1:0]  na;
		logic [ANG_W-1:0]  sa;
		logic [ANG_W-1:0]  la;
	} feature_t;

	logic clk, arst_n, start, busy;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [DSQ_W-1:0] cfg_data;
	logic done;
	logic [1:0] status;
	logic [DSQ_W-1:0] distance_sq;
	logic [DIST_W-1:0] distance;
	logic [ANG_W-1:0] normal_angle, small_angle, large_angle;

	pair_t drv;             // item currently on the input ports
	pair_t pending [$];     // items still to be offered
	feature_t features [$]; // predicted results, oldest first
	logic [DSQ_W-1:0] band_lo, band_hi;
	bit gappy;              // sender idles at random when set
	int errors, n_items, n_results;
	int cycles;

	point_pair_feature DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_pos_x(drv.fp[0]), .first_pos_y(drv.fp[1]), .first_pos_z(drv.fp[2]),
		.first_norm_x(drv.fn[0]), .first_norm_y(drv.fn[1]), .first_norm_z(drv.fn[2]),
		.second_pos_x(drv.sp[0]), .second_pos_y(drv.sp[1]), .second_pos_z(drv.sp[2]),
		.second_norm_x(drv.sn[0]), .second_norm_y(drv.sn[1]), .second_norm_z(drv.sn[2]),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .status(status), .distance_sq(distance_sq),
		.distance(distance), .normal_angle(normal_angle), .small_angle(small_angle),
		.large_angle(large_angle)
	);

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// acos of a Q.16 cosine in [0,1] by vectoring rotations, Q1.14 out
	function automatic logic [ANG_W-1:0] angle_of_cos(longint unsigned c);
		longint x, y, z, nx;
		longint unsigned a;
		if (c >= 65536)
			return '0;
		x = longint'(c << 14);
		y = longint'(int_sqrt(((64'd1 << 32) - c * c) << 28));
		z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN_TAB[i];
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN_TAB[i];
			end
			x = nx;
		end
		if (z < 0)
			z = 0;
		if (z > longint'(HALF_PI_Q30))
			z = longint'(HALF_PI_Q30);
		a = (longint'(z) + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
		return a > 64'h7fff ? ANGLE_MAX : a[ANG_W-1:0];
	endfunction

	function automatic feature_t ppf_predict(pair_t p);
		longint dv [3], a [3], b [3];
		longint dot_u, dot_v, dot_n;
		longint unsigned dsq, r, cu, cv;
		logic [ANG_W-1:0] au, av;
		feature_t f;
		dsq = 0;
		dot_u = 0;
		dot_v = 0;
		dot_n = 0;
		for (int k = 0; k < 3; k++) begin
			dv[k] = longint'(p.sp[k]) - longint'(p.fp[k]);
			a[k] = longint'(p.fn[k]);
			b[k] = longint'(p.sn[k]);
			dsq += mag(dv[k]) * mag(dv[k]);
		end
		if (dsq > DSQ_TOP)
			dsq = DSQ_TOP;
		f = '{st: ST_OK, dsq: dsq[DSQ_W-1:0], dlen: '0, na: '0, sa: '0, la: '0};
		if (dsq == 0) begin
			f.st = ST_SAME;
			return f;
		end
		if (dsq < band_lo || dsq > band_hi) begin
			f.st = ST_BAND;
			return f;
		end
		r = int_sqrt(dsq);
		if (dsq - r * r > r)
			r++;
		f.dlen = r > DIST_MAX ? DIST_MAX : r[DIST_W-1:0];
		for (int k = 0; k < 3; k++) begin
			dot_u += a[k] * dv[k];
			dot_v += b[k] * dv[k];
			dot_n += a[k] * b[k];
		end
		f.na = angle_of_cos((mag(dot_n) >> 14) > 65536 ? 65536 : mag(dot_n) >> 14);
		cu = (mag(dot_u) << 1) / r;
		cv = (mag(dot_v) << 1) / r;
		au = angle_of_cos(cu > 65536 ? 65536 : cu);
		av = angle_of_cos(cv > 65536 ? 65536 : cv);
		f.sa = au < av ? au : av;
		f.la = au < av ? av : au;
		return f;
	endfunction

	// random pair: 0 near pair, 1 anywhere, 2 coinciding
	function automatic pair_t rand_pair(int mode);
		pair_t p;
		int s;
		for (int k = 0; k < 3; k++) begin
			p.fp[k] = COORD_W'($urandom);
			s = $urandom_range(0, 23);
			p.sp[k] = (mode == 1) ? COORD_W'($urandom) :
				(mode == 2) ? p.fp[k] :
				p.fp[k] + COORD_W'(int'($urandom_range(0, 2 << s)) - (1 << s));
			p.fn[k] = NORM_W'($urandom);
			p.sn[k] = NORM_W'($urandom);
		end
		// now and then axis-aligned normals of length 32767, so normal cosines fall near one or at zero
		if ($urandom_range(0, 5) == 0) begin
			p.fn = '{16'sd0, 16'sd0, 16'sd0};
			p.sn = '{16'sd0, 16'sd0, 16'sd0};
			p.fn[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'sh7fff : -16'sh7fff;
			p.sn[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'sh7fff : -16'sh7fff;
		end
		return p;
	endfunction

	function automatic pair_t mk(int fx, int fy, int fz, int sx, int sy, int sz,
			int n1x, int n1y, int n1z, int n2x, int n2y, int n2z);
		pair_t p;
		p.fp = '{COORD_W'(fx), COORD_W'(fy), COORD_W'(fz)};
		p.sp = '{COORD_W'(sx), COORD_W'(sy), COORD_W'(sz)};
		p.fn = '{NORM_W'(n1x), NORM_W'(n1y), NORM_W'(n1z)};
		p.sn = '{NORM_W'(n2x), NORM_W'(n2y), NORM_W'(n2z)};
		return p;
	endfunction

	task automatic write_band(cfg_reg_t idx, logic [DSQ_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MIN_DIST_SQ)
			band_lo = v;
		else
			band_hi = v;
		cfg_valid <= 1'b0;
	endtask

	// sender pause: wait until every predicted result has been checked
	task automatic drain;
		do @(posedge clk); while (pending.size() != 0 || start || features.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_random(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			pending.push_back(rand_pair(r < 70 ? 0 : (r < 92 ? 1 : 2)));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sender: offers the next queued item, idling at random when gappy
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				features.push_back(ppf_predict(drv));
				n_items++;
			end
			if (!start || !busy) begin
				if (pending.size() != 0 && !(gappy && $urandom_range(0, 99) < 34)) begin
					drv <= pending.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// checker: every done cycle is held against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (features.size() == 0) begin
				$display("%0t: unexpected result, status %0d dsq %0h", $time, status,
					distance_sq);
				errors++;
			end else begin
				feature_t e;
				e = features.pop_front();
				n_results++;
				if (status !== e.st || distance_sq !== e.dsq || distance !== e.dlen ||
						normal_angle !== e.na || small_angle !== e.sa ||
						large_angle !== e.la) begin
					$display("%0t: mismatch exp st %0d dsq %0h dist %0h ang %0h %0h %0h",
						$time, e.st, e.dsq, e.dlen, e.na, e.sa, e.la);
					$display("%0t:          got st %0d dsq %0h dist %0h ang %0h %0h %0h",
						$time, status, distance_sq, distance, normal_angle, small_angle,
						large_angle);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < 3; k++) begin
			drv.fp[k] = '0;
			drv.sp[k] = '0;
			drv.fn[k] = '0;
			drv.sn[k] = '0;
		end
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MIN_DIST_SQ;
		cfg_data = '0;
		band_lo = '0;
		band_hi = MAX_DSQ_RST;
		gappy = 1'b0;
		errors = 0;
		n_items = 0;
		n_results = 0;
		cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed items at reset band, sender never idles
		pending.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));        // same point
		pending.push_back(mk(5, -7, 9, 5, -7, 9, 32767, 0, 0, 0, 32767, 0));
		pending.push_back(mk(0, 0, 0, 1, 0, 0, 32767, 0, 0, 32767, 0, 0)); // tiny, parallel
		pending.push_back(mk(0, 0, 0, 65536, 0, 0, 0, 32767, 0, 0, 0, 32767));
		pending.push_back(mk(0, 0, 0, 0, 65536, 0, 32767, 0, 0, 0, 0, -32768));
		// widest pair on all axes, largest distance
		pending.push_back(mk(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
			-32768, -32768, -32768, 32767, 32767, 32767));
		pending.push_back(mk(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
			32767, -32768, 32767, -32768, 32767, -32768));
		pending.push_back(mk(8388607, 0, 0, -8388608, 0, 0, 23170, 23170, 0, 0, 23170, 23170));
		// non-unit normals, cosines clamp
		pending.push_back(mk(0, 0, 0, 300, 400, 0, -32768, -32768, -32768,
			-32768, -32768, -32768));
		pending.push_back(mk(100, 200, 300, -400, 50, 9000, 18918, 18918, 18918,
			-18918, 18918, -18918));
		pending.push_back(mk(0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0));          // zero normals
		pending.push_back(mk(-1, -1, -1, 0, 0, 0, 1, -1, 1, -1, 1, -1));
		load_random(350);
		drain();
		$display("phase 1 done: %0d items", n_items);

		// narrow band, both bounds cut, sender idles from now on
		gappy = 1'b1;
		write_band(REG_MIN_DIST_SQ, 50'd1 << 20);
		write_band(REG_MAX_DIST_SQ, 50'd1 << 40);
		pending.push_back(mk(0, 0, 0, 1023, 0, 0, 32767, 0, 0, 32767, 0, 0)); // just below
		pending.push_back(mk(0, 0, 0, 1024, 0, 0, 32767, 0, 0, 32767, 0, 0)); // on lower
		pending.push_back(mk(0, 0, 0, 1048576, 0, 0, 0, 32767, 0, 32767, 0, 0)); // on upper
		pending.push_back(mk(0, 0, 0, 1048577, 0, 0, 0, 32767, 0, 32767, 0, 0)); // above
		load_random(350);
		drain();

		// inverted band: every nonzero distance is out of band
		write_band(REG_MIN_DIST_SQ, DSQ_MAX);
		write_band(REG_MAX_DIST_SQ, '0);
		load_random(350);
		drain();

		// widest band the registers hold
		write_band(REG_MIN_DIST_SQ, '0);
		write_band(REG_MAX_DIST_SQ, DSQ_MAX);
		load_random(350);
		drain();

		// single-value band, then random bounds
		write_band(REG_MIN_DIST_SQ, 50'd1 << 32);
		write_band(REG_MAX_DIST_SQ, 50'd1 << 32);
		pending.push_back(mk(0, 0, 0, 0, 0, 65536, 32767, 0, 0, 0, 0, 32767));
		load_random(150);
		drain();
		write_band(REG_MIN_DIST_SQ, DSQ_W'({$urandom, $urandom} & ((64'd1 << 36) - 1)));
		write_band(REG_MAX_DIST_SQ, DSQ_W'({$urandom, $urandom} & ((64'd1 << 46) - 1)));
		load_random(250);
		drain();

		$display("Covered %0d items, %0d results checked over six band settings,",
			n_items, n_results);
		$display("including same-point, out-of-band, inverted and extreme-coordinate pairs.");
		if (errors == 0 && features.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
